// ----- sv/ground_barrier_force_assert.svh -----
`ifndef GROUND_BARRIER_FORCE_ASSERT_SVH
`define GROUND_BARRIER_FORCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/gbf_pkg.sv -----
package gbf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LOG_W     = 5 + FRAC_BITS;
    localparam int LP_W      = LOG_W + 32;
    localparam int AP_W      = 32 + LOG_W;
    localparam int A_W       = AP_W + 1 - FRAC_BITS;
    localparam int DIV_BITS  = 63;

    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [30:0] ONE_Q   = 31'(1 << FRAC_BITS);
    localparam logic [63:0] HALF_Q  = 64'(1) << (FRAC_BITS - 1);

    localparam int ST_IN   = 0;
    localparam int ST_NORM = 1;
    localparam int ST_SQ0  = 2;
    localparam int ST_DIFF = ST_SQ0 + FRAC_BITS;
    localparam int ST_LNP  = ST_DIFF + 1;
    localparam int ST_LN   = ST_LNP + 1;
    localparam int ST_AP   = ST_LN + 1;
    localparam int ST_A    = ST_AP + 1;
    localparam int ST_DIV0 = ST_A + 1;
    localparam int ST_MAG  = ST_DIV0 + DIV_BITS;
    localparam int ST_MUL  = ST_MAG + 1;
    localparam int ST_PROD = ST_MUL + 1;
    localparam int ST_FOUT = ST_PROD + 1;
    localparam int NST     = ST_FOUT + 1;

    typedef enum logic [7:0] {
        REG_DIST  = 8'd0,
        REG_STIFF = 8'd1
    } t_reg_idx;

    typedef struct packed {
        logic [31:0]          z;
        logic [31:0]          f;
        logic                 act;
        logic [30:0]          u;
        logic [4:0]           pd;
        logic [31:0]          md;
        logic [FRAC_BITS-1:0] fd;
        logic [4:0]           pz;
        logic [31:0]          mz;
        logic [FRAC_BITS-1:0] fz;
        logic [61:0]          uu;
        logic [LOG_W-1:0]     diff;
        logic [LP_W-1:0]      lp;
        logic [LOG_W-1:0]     lnr;
        logic [AP_W-1:0]      ap;
        logic [A_W-1:0]       a;
        logic [30:0]          rem;
        logic [62:0]          dvd;
        logic [62:0]          q;
        logic [63:0]          mag;
        logic [62:0]          hi;
        logic [62:0]          lo;
        logic [31:0]          prod;
        logic                 sat;
        logic [31:0]          fout;
    } t_item;

endpackage

// ----- sv/ground_barrier_force.sv -----
// Channel   Direction  Payload
// s_axis    in         tdata: height, force_in_z
// m_axis    out        tdata: force_out_z, barrier_term; tuser: active, saturated
// cfg       in         index 0 barrier_distance, index 1 stiffness
//
// One beat per clock in and out unless the skid register is full; a beat passes
// through the log squaring stages and then the one-bit-per-stage divider.
// Reset clears all valid bits and sets both registers to 1.0.
// A skid register ahead of the output register keeps the input open while a result waits;
// the whole pipeline holds only when the skid register is full.
module ground_barrier_force (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // height [31:0], force_in_z [63:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // force_out_z [31:0], barrier_term [63:32]
    output logic [1:0]  m_axis_tuser,  // active [0], saturated [1]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int NST = gbf_pkg::NST;
    localparam int F   = gbf_pkg::FRAC_BITS;

    logic [30:0]          r_dist;
    logic [30:0]          r_stiff;
    logic [NST-1:0]       r_vld;
    gbf_pkg::t_item       r_st [NST];
    gbf_pkg::t_item       n_st [NST];
    logic                 w_en;
    logic                 r_out_vld;
    logic [63:0]          r_out_data;
    logic [1:0]           r_out_user;
    logic                 r_skid_vld;
    logic [63:0]          r_skid_data;
    logic [1:0]           r_skid_user;
    logic [63:0]          w_arr_data;
    logic [1:0]           w_arr_user;
    logic                 w_out_free;

    function automatic logic [4:0] f_top(input logic [30:0] v);
        logic [4:0] p;
        p = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [32:0] f_sq(input logic [31:0] m);
        logic [63:0] sq;
        logic [31:0] mm;
        sq = {32'd0, m} * {32'd0, m};
        mm = sq[61:30];
        if (mm[31]) begin
            return {1'b1, 1'b0, mm[31:1]};
        end
        return {1'b0, mm};
    endfunction

    assign o_cfg_ready   = 1'b1;
    assign w_en          = !r_skid_vld;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= gbf_pkg::ONE_Q;
            r_stiff <= gbf_pkg::ONE_Q;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gbf_pkg::REG_DIST:  r_dist  <= i_cfg_data[30:0];
                gbf_pkg::REG_STIFF: r_stiff <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_st[0]     = '0;
        n_st[0].z   = s_axis_tdata[31:0];
        n_st[0].f   = s_axis_tdata[63:32];
        n_st[0].act = !s_axis_tdata[31] && (s_axis_tdata[30:0] != 31'd0)
                      && (s_axis_tdata[30:0] < r_dist);
        n_st[0].u   = r_dist - s_axis_tdata[30:0];
    end

    for (genvar g = 1; g < NST; g++) begin : g_stage
        if (g == gbf_pkg::ST_NORM) begin : g_norm
            logic [4:0] w_pd;
            logic [4:0] w_pz;
            always_comb begin
                w_pd       = f_top(r_dist);
                w_pz       = f_top(r_st[g-1].z[30:0]);
                n_st[g]    = r_st[g-1];
                n_st[g].pd = w_pd;
                n_st[g].pz = w_pz;
                n_st[g].md = {1'b0, r_dist} << (5'd30 - w_pd);
                n_st[g].mz = {1'b0, r_st[g-1].z[30:0]} << (5'd30 - w_pz);
                n_st[g].fd = '0;
                n_st[g].fz = '0;
                n_st[g].uu = {31'd0, r_st[g-1].u} * {31'd0, r_st[g-1].u};
            end
        end else if (g >= gbf_pkg::ST_SQ0 && g < gbf_pkg::ST_DIFF) begin : g_sq
            logic [32:0] w_d;
            logic [32:0] w_z;
            always_comb begin
                w_d        = f_sq(r_st[g-1].md);
                w_z        = f_sq(r_st[g-1].mz);
                n_st[g]    = r_st[g-1];
                n_st[g].md = w_d[31:0];
                n_st[g].mz = w_z[31:0];
                n_st[g].fd = {r_st[g-1].fd[F-2:0], w_d[32]};
                n_st[g].fz = {r_st[g-1].fz[F-2:0], w_z[32]};
            end
        end else if (g == gbf_pkg::ST_DIFF) begin : g_diff
            logic [gbf_pkg::LOG_W-1:0] w_ld;
            logic [gbf_pkg::LOG_W-1:0] w_lz;
            always_comb begin
                w_ld        = {r_st[g-1].pd, r_st[g-1].fd};
                w_lz        = {r_st[g-1].pz, r_st[g-1].fz};
                n_st[g]     = r_st[g-1];
                n_st[g].diff = (w_ld > w_lz) ? (w_ld - w_lz) : '0;
                n_st[g].dvd = {1'b0, r_st[g-1].uu} + {33'd0, r_st[g-1].z[30:1]};
                n_st[g].rem = '0;
                n_st[g].q   = '0;
            end
        end else if (g == gbf_pkg::ST_LNP) begin : g_lnp
            always_comb begin
                n_st[g]    = r_st[g-1];
                n_st[g].lp = {32'd0, r_st[g-1].diff} * {{gbf_pkg::LOG_W{1'b0}}, gbf_pkg::LN2_Q32};
            end
        end else if (g == gbf_pkg::ST_LN) begin : g_ln
            logic [gbf_pkg::LP_W:0] w_ls;
            always_comb begin
                w_ls        = {1'b0, r_st[g-1].lp} + (gbf_pkg::LP_W + 1)'(64'd1 << 31);
                n_st[g]     = r_st[g-1];
                n_st[g].lnr = w_ls[32 +: gbf_pkg::LOG_W];
            end
        end else if (g == gbf_pkg::ST_AP) begin : g_ap
            always_comb begin
                n_st[g]    = r_st[g-1];
                n_st[g].ap = {{gbf_pkg::LOG_W{1'b0}}, r_st[g-1].u, 1'b0}
                             * {32'd0, r_st[g-1].lnr};
            end
        end else if (g == gbf_pkg::ST_A) begin : g_a
            logic [gbf_pkg::AP_W:0] w_as;
            always_comb begin
                w_as      = {1'b0, r_st[g-1].ap} + (gbf_pkg::AP_W + 1)'(gbf_pkg::HALF_Q);
                n_st[g]   = r_st[g-1];
                n_st[g].a = w_as[F +: gbf_pkg::A_W];
            end
        end else if (g >= gbf_pkg::ST_DIV0 && g < gbf_pkg::ST_MAG) begin : g_div
            logic [31:0] w_r;
            logic [31:0] w_s;
            logic        w_ge;
            always_comb begin
                w_r         = {r_st[g-1].rem, r_st[g-1].dvd[62]};
                w_ge        = w_r >= {1'b0, r_st[g-1].z[30:0]};
                w_s         = w_r - {1'b0, r_st[g-1].z[30:0]};
                n_st[g]     = r_st[g-1];
                n_st[g].rem = w_ge ? w_s[30:0] : w_r[30:0];
                n_st[g].dvd = {r_st[g-1].dvd[61:0], 1'b0};
                n_st[g].q   = {r_st[g-1].q[61:0], w_ge};
            end
        end else if (g == gbf_pkg::ST_MAG) begin : g_mag
            always_comb begin
                n_st[g]     = r_st[g-1];
                n_st[g].mag = 64'(r_st[g-1].a) + {1'b0, r_st[g-1].q};
            end
        end else if (g == gbf_pkg::ST_MUL) begin : g_mul
            always_comb begin
                n_st[g]    = r_st[g-1];
                n_st[g].hi = {32'd0, r_stiff} * {31'd0, r_st[g-1].mag[63:32]};
                n_st[g].lo = {32'd0, r_stiff} * {31'd0, r_st[g-1].mag[31:0]};
            end
        end else if (g == gbf_pkg::ST_PROD) begin : g_prod
            logic [63:0] w_ps;
            logic [63:0] w_pv;
            logic        w_big;
            always_comb begin
                w_ps  = {{(32 - F){1'b0}}, r_st[g-1].hi[F-1:0], 32'd0}
                        + {1'b0, r_st[g-1].lo} + gbf_pkg::HALF_Q;
                w_pv  = w_ps >> F;
                w_big = (r_st[g-1].hi[62:F] != '0) || (w_pv > 64'h8000_0000);
                n_st[g] = r_st[g-1];
                if (!r_st[g-1].act) begin
                    n_st[g].prod = 32'd0;
                    n_st[g].sat  = 1'b0;
                end else begin
                    n_st[g].prod = w_big ? 32'h8000_0000 : w_pv[31:0];
                    n_st[g].sat  = w_big;
                end
            end
        end else begin : g_fout
            logic [33:0] w_fs;
            logic        w_big;
            always_comb begin
                w_fs  = {{2{r_st[g-1].f[31]}}, r_st[g-1].f} + {2'b0, r_st[g-1].prod};
                w_big = !w_fs[33] && (w_fs[32] || w_fs[31]);
                n_st[g]      = r_st[g-1];
                n_st[g].fout = w_big ? 32'h7FFF_FFFF : w_fs[31:0];
                n_st[g].sat  = r_st[g-1].sat || w_big;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < NST; i++) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign w_arr_data = {32'd0 - r_st[NST-1].prod, r_st[NST-1].fout};
    assign w_arr_user = {r_st[NST-1].sat, r_st[NST-1].act};
    assign w_out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_out_free) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_vld <= r_vld[NST-1];
        end else if (r_vld[NST-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_out_free) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (w_out_free) begin
            r_out_data <= w_arr_data;
            r_out_user <= w_arr_user;
        end else begin
            r_skid_data <= w_arr_data;
            r_skid_user <= w_arr_user;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`include "ground_barrier_force_assert.svh"

    `GBF_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld, "skid full while output empty")
    `GBF_ASSERT_NOW(a_idle_zero_term, m_axis_tvalid && !m_axis_tuser[0],
                    m_axis_tdata[63:32] == 32'd0, "inactive beat with nonzero term")
    `GBF_ASSERT_NOW(a_term_sign, m_axis_tvalid,
                    m_axis_tdata[63] || (m_axis_tdata[63:32] == 32'd0), "positive term")
    `GBF_ASSERT_NEXT(a_stall_holds, !w_en, $stable(r_vld), "pipeline moved during stall")

endmodule

// ----- bench/tb_ground_barrier_force.sv -----
`timescale 1ns / 1ps

module tb_ground_barrier_force;

    localparam int FB = 16;
    localparam longint unsigned LN2_FIX = 64'd2977044472;
    localparam int DRAIN_CYCLES = 200;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [31:0] force_out_z;
        logic [31:0] barrier_term;
        logic        active;
        logic        saturated;
    } t_force_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    ground_barrier_force u_dut (.*);

    logic [63:0]   vertex_queue[$];
    t_force_result expected_forces[$];
    longint unsigned dist_reg;
    longint unsigned stiff_reg;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_sender;
    int  error_count;
    int  result_count;
    int  active_count;
    int  sat_count;
    int  quiet_cycles;
    bit  cfg_pending;
    logic [7:0]  cfg_idx_next;
    logic [31:0] cfg_data_next;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned fixed_log2(longint unsigned v);
        int unsigned top;
        longint unsigned mant;
        longint unsigned frac;
        top = 0;
        frac = 0;
        for (int i = 0; i < 31; i++) begin
            if (v[i]) top = i;
        end
        mant = (v << (30 - top)) & 64'hFFFF_FFFF;
        for (int i = 0; i < FB; i++) begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= 64'h8000_0000) begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return (longint'(top) << FB) | frac;
    endfunction

    function automatic t_force_result barrier_predict(logic [31:0] h, logic [31:0] fz);
        t_force_result r;
        longint z;
        longint f;
        longint term;
        longint fout;
        longint unsigned u, ld, lz, dlog, lnr, a, b, mag, hi, lo, prod;
        longint unsigned half;
        half = 64'd1 << (FB - 1);
        z = longint'($signed(h));
        f = longint'($signed(fz));
        term = 0;
        r.active = 1'b0;
        r.saturated = 1'b0;
        if (z > 0 && z < longint'(dist_reg)) begin
            u = dist_reg - z;
            ld = fixed_log2(dist_reg);
            lz = fixed_log2(z);
            dlog = (ld > lz) ? ld - lz : 0;
            lnr = (dlog * LN2_FIX + 64'h8000_0000) >> 32;
            a = (2 * u * lnr + half) >> FB;
            b = (u * u + (z >> 1)) / z;
            mag = a + b;
            hi = stiff_reg * (mag >> 32);
            lo = stiff_reg * (mag & 64'hFFFF_FFFF);
            r.active = 1'b1;
            if ((hi >> FB) != 0) begin
                prod = 64'h8000_0000;
                r.saturated = 1'b1;
            end else begin
                prod = ((hi << 32) + lo + half) >> FB;
                if (prod > 64'h8000_0000) begin
                    prod = 64'h8000_0000;
                    r.saturated = 1'b1;
                end
            end
            term = -longint'(prod);
        end
        fout = f - term;
        if (fout > 64'sd2147483647) begin
            fout = 64'sd2147483647;
            r.saturated = 1'b1;
        end
        r.force_out_z = fout[31:0];
        r.barrier_term = term[31:0];
        return r;
    endfunction

    // Driver: input stream and register writes.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            i_cfg_valid <= 1'b0;
            i_cfg_index <= '0;
            i_cfg_data <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == gbf_pkg::REG_DIST) dist_reg = 64'(i_cfg_data[30:0]);
                else if (i_cfg_index == gbf_pkg::REG_STIFF) stiff_reg = 64'(i_cfg_data[30:0]);
                cfg_pending = 1'b0;
                i_cfg_valid <= 1'b0;
            end else if (cfg_pending && !i_cfg_valid) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= cfg_idx_next;
                i_cfg_data <= cfg_data_next;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_forces.push_back(
                    barrier_predict(s_axis_tdata[31:0], s_axis_tdata[63:32]));
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (vertex_queue.size() > 0 && !hold_sender &&
                        $urandom_range(99) >= send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= vertex_queue.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: output stream, comparison and watchdog.
    always @(posedge i_clk) begin
        t_force_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                    (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else if (s_axis_tvalid || expected_forces.size() > 0 || cfg_pending)
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired", $time);
                $display("end of test: mismatches");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.force_out_z = m_axis_tdata[31:0];
                got.barrier_term = m_axis_tdata[63:32];
                got.active = m_axis_tuser[0];
                got.saturated = m_axis_tuser[1];
                if (expected_forces.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual %h", $time, got);
                    error_count++;
                end else begin
                    want = expected_forces.pop_front();
                    result_count++;
                    active_count += int'(got.active);
                    sat_count += int'(got.saturated);
                    if (got.force_out_z !== want.force_out_z)
                        $display("%0t: force_out_z expected %h actual %h", $time,
                                 want.force_out_z, got.force_out_z);
                    if (got.barrier_term !== want.barrier_term)
                        $display("%0t: barrier_term expected %h actual %h", $time,
                                 want.barrier_term, got.barrier_term);
                    if (got.active !== want.active)
                        $display("%0t: active expected %b actual %b", $time,
                                 want.active, got.active);
                    if (got.saturated !== want.saturated)
                        $display("%0t: saturated expected %b actual %b", $time,
                                 want.saturated, got.saturated);
                    if (got !== want) error_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        while (vertex_queue.size() > 0 || s_axis_tvalid || expected_forces.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(gbf_pkg::t_reg_idx idx, logic [31:0] value);
        wait_drained();
        cfg_idx_next = idx;
        cfg_data_next = value;
        cfg_pending = 1'b1;
        while (cfg_pending) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_height();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 6 && dist_reg > 1) return 32'($urandom_range(32'(dist_reg - 1), 1));
        if (sel == 6) return 32'(dist_reg + 64'($urandom_range(3)));
        if (sel == 7) return 32'($urandom_range(2)) ;
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_force();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF - $urandom_range(1000);
            1: return 32'h8000_0000 + $urandom_range(1000);
            default: return $urandom();
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            vertex_queue.push_back({pick_force(), pick_height()});
    endtask

    initial begin
        dist_reg = 64'd65536;
        stiff_reg = 64'd65536;
        send_idle_pct = 14;
        recv_idle_pct = 74;
        hold_sender = 1'b0;
        cfg_pending = 1'b0;
        error_count = 0;
        result_count = 0;
        active_count = 0;
        sat_count = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items under reset settings: band edges and force extremes.
        vertex_queue.push_back({32'h0000_0000, 32'h0000_0000});
        vertex_queue.push_back({32'h7FFF_FFFF, 32'h0000_0001});
        vertex_queue.push_back({32'h8000_0000, 32'h0000_8000});
        vertex_queue.push_back({32'h7FFF_FFF0, 32'h0000_0100});
        vertex_queue.push_back({32'h1234_5678, 32'h0000_FFFF});
        vertex_queue.push_back({32'hFFFF_FFFF, 32'h0001_0000});
        vertex_queue.push_back({32'h0000_0000, 32'h8000_0000});
        vertex_queue.push_back({32'hFFFF_0000, 32'hFFFF_FFFF});
        vertex_queue.push_back({32'h0000_0000, 32'h0001_0001});
        random_phase(60);
        write_reg(gbf_pkg::REG_STIFF, 32'h7FFF_FFFF);
        vertex_queue.push_back({32'h7FFF_0000, 32'h0000_0001});
        vertex_queue.push_back({32'h0000_0000, 32'h0000_8000});
        random_phase(60);
        write_reg(gbf_pkg::REG_STIFF, 32'h0000_0000);
        vertex_queue.push_back({32'h1000_0000, 32'h0000_4000});
        random_phase(30);
        write_reg(gbf_pkg::REG_DIST, 32'hFFFF_FFFF);
        write_reg(gbf_pkg::REG_STIFF, 32'h8000_0100);
        vertex_queue.push_back({32'h0000_0000, 32'h0000_0001});
        vertex_queue.push_back({32'h0000_0000, 32'h7FFF_FFFE});
        random_phase(80);

        // Pause until every expected result has come, then swap idle rates.
        hold_sender = 1'b1;
        while (expected_forces.size() > 0) @(posedge i_clk);
        hold_sender = 1'b0;
        send_idle_pct = 74;
        recv_idle_pct = 14;
        write_reg(gbf_pkg::REG_DIST, 32'h0000_0001);
        random_phase(20);
        write_reg(gbf_pkg::REG_DIST, 32'h0000_0002);
        random_phase(20);
        write_reg(gbf_pkg::REG_DIST, 32'h0100_0000);
        write_reg(gbf_pkg::REG_STIFF, 32'h0004_0000);
        random_phase(90);
        write_reg(gbf_pkg::t_reg_idx'(8'd7), 32'h0000_1234);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(gbf_pkg::REG_DIST, 32'h0000_4000);
        write_reg(gbf_pkg::REG_STIFF, 32'h0000_0100);
        random_phase(90);
        write_reg(gbf_pkg::REG_DIST, 32'h0010_0000);
        random_phase(80);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results, %0d in the barrier band, %0d saturated,",
                 result_count, active_count, sat_count);
        $display("across several distance and stiffness settings and idle patterns.");
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

// ----- ground_barrier_force.f -----
+incdir+sv
sv/gbf_pkg.sv
sv/ground_barrier_force.sv
bench/tb_ground_barrier_force.sv
